### sv/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared constants, register codes and helpers of the modulated delay chorus.
// ----------------------------------------------------------------------------
package mdc_pkg;

    // default sizes
    localparam int DELAY_DEPTH_DEF  = 65536;
    localparam int SINE_ENTRIES_DEF = 1024;

    // sample and configuration port widths
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd4;

    // configuration reset values
    localparam logic               ENABLE_RST        = 1'b1;
    localparam logic [15:0]        BASE_DELAY_RST    = 16'd441;
    localparam logic [15:0]        MOD_DEPTH_RST     = 16'd88;
    localparam logic [31:0]        PHASE_STEP_RST    = 32'd194783;
    localparam logic signed [15:0] FEEDBACK_GAIN_RST = 16'sd0;

    // quarter-wave sine polynomial coefficients (Q16)
    localparam int SINE_A  = 42334;
    localparam int SINE_C1 = 5223;
    localparam int SINE_B  = 102944;

    // saturate an 18-bit signed sum to a 16-bit sample
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### sv/mdc_in_if.sv
// ----------------------------------------------------------------------------
// mdc_in_if
// Input sample channel: valid/ready handshake carrying one sample.
// ----------------------------------------------------------------------------
interface mdc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

### sv/mdc_out_if.sv
// ----------------------------------------------------------------------------
// mdc_out_if
// Output sample channel: valid/ready handshake carrying one result sample.
// ----------------------------------------------------------------------------
interface mdc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

### sv/mdc_sine.sv
// ----------------------------------------------------------------------------
// mdc_sine
// Seven-stage LFO sine pipeline: phase to table index, quadrant fold and
// quarter-wave polynomial, at most one multiplier per stage.
// ----------------------------------------------------------------------------
module mdc_sine
    import mdc_pkg::*;
#(
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               adv,
    input  logic [31:0]        phase,
    output logic signed [15:0] sine
);

    localparam int SL = $clog2(SINE_ENTRIES);
    localparam int NB = 16 + SL;
    localparam int MW = NB + 2;
    // reciprocal for exact floor(rem * 65536 / SINE_ENTRIES)
    localparam logic [63:0] RECIP =
        ((64'd1 << (NB + SL)) + 64'(SINE_ENTRIES) - 64'd1) / 64'(SINE_ENTRIES);
    localparam logic [SL:0]   SE_C = (SL + 1)'(SINE_ENTRIES);
    localparam logic [SL+1:0] SE1  = (SL + 2)'(SINE_ENTRIES);
    localparam logic [SL+1:0] SE2  = (SL + 2)'(2 * SINE_ENTRIES);
    localparam logic [SL+1:0] SE3  = (SL + 2)'(3 * SINE_ENTRIES);

    // stage 1: table index
    logic [SL+32:0] idx_prod;
    logic [SL-1:0]  idx_next, idx_reg;

    // stage 2: quadrant and remainder
    logic [SL+1:0]  u_val;
    logic [1:0]     quad_next, quad_reg;
    logic [SL-1:0]  rem_next, rem_reg;

    // stage 3: folded Q16 angle
    logic [SL+MW-1:0] q_prod;
    logic [15:0]      q_val;
    logic [16:0]      p3_next, p3_reg;
    logic             neg3_reg;

    // stage 4: square
    logic [33:0] pp_prod;
    logic [16:0] x2_4_next, x2_4_reg, p4_reg;
    logic        neg4_reg;

    // stage 5: first polynomial term
    logic [29:0] k_prod;
    logic [15:0] t5_next, t5_reg;
    logic [16:0] x2_5_reg, p5_reg;
    logic        neg5_reg;

    // stage 6: second polynomial term
    logic [32:0] m_prod;
    logic [16:0] t2_6_next, t2_6_reg, p6_reg;
    logic        neg6_reg;

    // stage 7: final product, cap and sign
    logic [33:0]        r_prod;
    logic [16:0]        r_val;
    logic signed [15:0] mag;
    logic signed [15:0] sine_next, sine_reg;

    always_comb
    begin
        idx_prod = phase * SE_C;
        idx_next = idx_prod[32 +: SL];

        u_val = {idx_reg, 2'b00};
        if (u_val >= SE3)
        begin
            quad_next = 2'd3;
            rem_next  = SL'(u_val - SE3);
        end
        else if (u_val >= SE2)
        begin
            quad_next = 2'd2;
            rem_next  = SL'(u_val - SE2);
        end
        else if (u_val >= SE1)
        begin
            quad_next = 2'd1;
            rem_next  = SL'(u_val - SE1);
        end
        else
        begin
            quad_next = 2'd0;
            rem_next  = u_val[SL-1:0];
        end

        q_prod  = rem_reg * MW'(RECIP);
        q_val   = q_prod[2*SL +: 16];
        p3_next = quad_reg[0] ? (17'h10000 - {1'b0, q_val}) : {1'b0, q_val};

        pp_prod   = p3_reg * p3_reg;
        x2_4_next = pp_prod[32:16];

        k_prod  = x2_4_reg * 13'(SINE_C1);
        t5_next = 16'(SINE_A) - {2'b00, k_prod[29:16]};

        m_prod    = x2_5_reg * t5_reg;
        t2_6_next = 17'(SINE_B) - m_prod[32:16];

        r_prod = p6_reg * t2_6_reg;
        r_val  = r_prod[33:17];
        mag    = (r_val > 17'd32767) ? 16'sd32767 : $signed({1'b0, r_val[14:0]});
        sine_next = neg6_reg ? -mag : mag;
    end

    // pipeline registers advance together with the rest of the datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg  <= idx_next;
            quad_reg <= quad_next;
            rem_reg  <= rem_next;
            p3_reg   <= p3_next;
            neg3_reg <= quad_reg[1];
            x2_4_reg <= x2_4_next;
            p4_reg   <= p3_reg;
            neg4_reg <= neg3_reg;
            t5_reg   <= t5_next;
            x2_5_reg <= x2_4_reg;
            p5_reg   <= p4_reg;
            neg5_reg <= neg4_reg;
            t2_6_reg <= t2_6_next;
            p6_reg   <= p5_reg;
            neg6_reg <= neg5_reg;
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

### sv/mdc_delay_ram.sv
// ----------------------------------------------------------------------------
// mdc_delay_ram
// Delay line memory: one write and one registered read per cycle, clearing
// sweep after reset and forwarding of a same-cycle write to the read.
// ----------------------------------------------------------------------------
module mdc_delay_ram
    import mdc_pkg::*;
#(
    parameter int DEPTH = DELAY_DEPTH_DEF,
    parameter int AW    = $clog2(DELAY_DEPTH_DEF)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic signed [15:0] wr_data,
    output logic signed [15:0] rd_data,
    output logic               ready
);

    logic signed [15:0] mem [DEPTH];

    logic [AW-1:0]      clr_idx_reg, clr_idx_next;
    logic               done_reg, done_next;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [15:0] mem_wd;
    logic signed [15:0] rd_q_reg;
    logic               fwd_reg, fwd_next;
    logic signed [15:0] fwd_data_reg;

    // clearing sweep, one entry per cycle
    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        done_next    = done_reg;
        if (!done_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == AW'(DEPTH - 1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            done_reg    <= done_next;
        end
    end

    // write port shared between sweep and datapath
    always_comb
    begin
        if (!done_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_idx_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = wr_en;
            mem_wa = wr_addr;
            mem_wd = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // forward a write that lands on the entry being read in the same cycle
    assign fwd_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;
    assign ready   = done_reg;

endmodule

### sv/modulated_delay_chorus.sv
// ----------------------------------------------------------------------------
// modulated_delay_chorus
// Mono chorus: sine LFO modulated tap into a circular delay line with
// feedback, dry plus tap mixed and saturated to 16 bits (dry only when disabled).
// ----------------------------------------------------------------------------
//  channel  dir  payload                       handshake
//  feed     in   sample_in  (16b signed Q1.15)  valid/ready
//  mix      out  sample_out (16b signed Q1.15)  valid/ready
//  cfg      in   cfg_index, cfg_data            cfg_we, no back-pressure
//
//  One sample per cycle sustained while the output is not stalled; an accepted
//  transaction passes the phase register, 7 LFO stages, tap offset, clamped
//  delay, memory read and output register before its result is output.
//  After reset the delay memory is swept to zero with feed.ready low;
//  configuration writes are taken during the sweep.
//  A stalled output freezes the whole pipeline, including memory traffic.
//  A read of the entry written in the same cycle takes forwarded data.
// ----------------------------------------------------------------------------
module modulated_delay_chorus
    import mdc_pkg::*;
#(
    parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mdc_in_if.sink                feed,
    mdc_out_if.source             mix,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int DW   = (AW + 1 > 18) ? AW + 1 : 18;
    localparam int NSTG = 11;
    localparam int TAP_STG  = 9;
    localparam int WR_STG   = 10;

    // configuration registers
    logic               enable_reg;
    logic [15:0]        base_delay_reg;
    logic [15:0]        mod_depth_reg;
    logic [31:0]        phase_step_reg;
    logic signed [15:0] feedback_gain_reg;

    // running state
    logic [31:0]   lfo_phase_reg, lfo_phase_next;
    logic [AW-1:0] widx_reg, widx_next;

    // side pipeline
    logic [NSTG-1:0]    s_vld_reg;
    logic [NSTG-1:0]    s_en_reg;
    logic signed [15:0] s_x_reg    [NSTG];
    logic [AW-1:0]      s_widx_reg [NSTG];
    logic [31:0]        s0_phase_reg;

    logic adv;
    logic acc;
    logic ram_ready;

    logic signed [15:0] sine;
    logic signed [32:0] depth_prod;
    logic signed [17:0] term_next, term_reg;
    logic signed [DW-1:0] dsum;
    logic [AW-1:0]      d_next, d_reg;
    logic [AW:0]        diff;
    logic [AW:0]        wrap_sum;
    logic [AW-1:0]      rd_addr;

    logic signed [15:0] y;
    logic signed [31:0] fb_prod;
    logic signed [16:0] fb_term;
    logic signed [15:0] stored;
    logic signed [15:0] result;
    logic               wr_en;

    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_data_reg, out_data_next;

    // handshake
    assign adv        = !out_valid_reg || mix.ready;
    assign feed.ready = ram_ready && adv;
    assign acc        = feed.valid && feed.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= ENABLE_RST;
            base_delay_reg    <= BASE_DELAY_RST;
            mod_depth_reg     <= MOD_DEPTH_RST;
            phase_step_reg    <= PHASE_STEP_RST;
            feedback_gain_reg <= FEEDBACK_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:        enable_reg        <= cfg_data[0];
                CFG_BASE_DELAY:    base_delay_reg    <= cfg_data[15:0];
                CFG_MOD_DEPTH:     mod_depth_reg     <= cfg_data[15:0];
                CFG_PHASE_STEP:    phase_step_reg    <= cfg_data[31:0];
                CFG_FEEDBACK_GAIN: feedback_gain_reg <= $signed(cfg_data[15:0]);
                default:           ;
            endcase
        end
    end

    // lfo phase and write index advance per chorus transaction
    always_comb
    begin
        lfo_phase_next = lfo_phase_reg;
        widx_next      = widx_reg;
        if (acc && enable_reg)
        begin
            lfo_phase_next = lfo_phase_reg + phase_step_reg;
            widx_next      = (widx_reg == AW'(DELAY_DEPTH - 1)) ? '0 : widx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_phase_reg <= '0;
            widx_reg      <= '0;
        end
        else
        begin
            lfo_phase_reg <= lfo_phase_next;
            widx_reg      <= widx_next;
        end
    end

    // valid bits of the side pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg <= '0;
        end
        else if (adv)
        begin
            s_vld_reg <= {s_vld_reg[NSTG-2:0], acc};
        end
    end

    // sample, mode and write index travel along with the item
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_en_reg      <= {s_en_reg[NSTG-2:0], enable_reg};
            s_x_reg[0]    <= feed.sample_in;
            s_widx_reg[0] <= widx_reg;
            s0_phase_reg  <= lfo_phase_reg;
            for (int i = 1; i < NSTG; i++)
            begin
                s_x_reg[i]    <= s_x_reg[i-1];
                s_widx_reg[i] <= s_widx_reg[i-1];
            end
        end
    end

    // lfo sine
    mdc_sine #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_sine (
        .clk  (clk),
        .adv  (adv),
        .phase(s0_phase_reg),
        .sine (sine)
    );

    // tap offset, clamped tap delay and read address
    always_comb
    begin
        depth_prod = $signed({1'b0, mod_depth_reg}) * sine;
        term_next  = depth_prod[32:15];

        dsum = $signed({{(DW - 16){1'b0}}, base_delay_reg}) + DW'(term_reg);
        if (dsum < 0)
        begin
            d_next = '0;
        end
        else if (dsum > $signed(DW'(DELAY_DEPTH - 1)))
        begin
            d_next = AW'(DELAY_DEPTH - 1);
        end
        else
        begin
            d_next = dsum[AW-1:0];
        end

        diff     = {1'b0, s_widx_reg[TAP_STG]} - {1'b0, d_reg};
        wrap_sum = diff + (AW + 1)'(DELAY_DEPTH);
        rd_addr  = diff[AW] ? wrap_sum[AW-1:0] : diff[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_reg <= term_next;
            d_reg    <= d_next;
        end
    end

    // delay line
    mdc_delay_ram #(
        .DEPTH(DELAY_DEPTH),
        .AW   (AW)
    ) u_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (adv),
        .rd_addr(rd_addr),
        .wr_en  (wr_en),
        .wr_addr(s_widx_reg[WR_STG]),
        .wr_data(stored),
        .rd_data(y),
        .ready  (ram_ready)
    );

    // feedback write-back and wet mix
    always_comb
    begin
        fb_prod = feedback_gain_reg * y;
        fb_term = fb_prod[31:15];
        stored  = sat16(18'(s_x_reg[WR_STG]) + 18'(fb_term));
        result  = sat16(18'(s_x_reg[WR_STG]) + 18'(y));
        wr_en   = adv && s_vld_reg[WR_STG] && s_en_reg[WR_STG];
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (adv)
        begin
            out_valid_next = s_vld_reg[WR_STG];
            out_data_next  = s_en_reg[WR_STG] ? result : s_x_reg[WR_STG];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign mix.valid      = out_valid_reg;
    assign mix.sample_out = out_data_reg;

`ifndef SYNTHESIS
    // no transaction taken while the memory sweep runs
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ram_ready)
        else $error("input accepted during delay line sweep");

    // pipeline is empty when the sweep finishes
    a_empty_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ram_ready) |-> (s_vld_reg == '0) && !out_valid_reg)
        else $error("pipeline busy at end of sweep");

    // pass-through leaves lfo and write index untouched
    a_bypass_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !enable_reg |=> $stable(lfo_phase_reg) && $stable(widx_reg))
        else $error("pass-through changed chorus state");

    // read address stays inside the line
    a_rd_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        s_vld_reg[TAP_STG] |-> ({1'b0, rd_addr} <= (AW + 1)'(DELAY_DEPTH - 1)))
        else $error("delay read address out of range");
`endif

endmodule
